// ----- sv/ism_pkg.sv -----
// shared types, constants and helpers of the integer stack machine
`default_nettype none
package ism_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 1024;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  // field widths
  localparam int CMD_W = 4;
  localparam int VAL_W = 31;

  // request queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_START = 4'd0;
  localparam logic [CMD_W-1:0] CMD_NUM   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INV   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DUP   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SWP   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DIV   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_MOD   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_END   = 4'd11;

  // magnitude limit of any computed value
  localparam logic signed [63:0] VALUE_LIMIT = 64'sd1000000000;

  // request passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic                    needs_two;
    logic signed [VAL_W-1:0] operand;
  } ism_req_t;

  // true when a result is out of the allowed range
  function automatic logic too_big(input logic signed [63:0] x);
    return (x > VALUE_LIMIT) || (x < -VALUE_LIMIT);
  endfunction

endpackage
`default_nettype wire

// ----- sv/integer_stack_machine_top.sv -----
// top level of the integer stack machine evaluator
//
//  channel | direction | tdata bits (low first)               | tuser
//  in_     | request   | command[3:0] operand[34:4] pad[39:35] | none
//  out_    | result    | result_value[30:0] error[31]          | none
//
// START, NUM, DUP, INV, SWP and END complete in the back end's idle state;
// POP, ADD and SUB then refill the second entry from memory (skipped when
// fewer than two entries remain); MUL first passes a registered product and
// a range check; DIV and MOD first wait on the one-bit-per-cycle divider.
// A two-entry queue decouples input from execution.
// Synchronous active-low reset empties the stack and the queue; END stalls
// while a previous result is still waiting on out_tready.
`default_nettype none
module integer_stack_machine_top import ism_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // command[3:0], operand[34:4]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // result_value[30:0], error[31]
);

  logic     q_valid, q_ready;
  ism_req_t q_req;
  logic signed [VAL_W-1:0] out_value;
  logic     out_err;

  ism_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tdata[CMD_W-1:0]),
    .in_operand (in_tdata[CMD_W+VAL_W-1:CMD_W]),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req)
  );

  ism_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value),
    .out_err   (out_err)
  );

  assign out_tdata = {out_err, out_value};

endmodule
`default_nettype wire

// ----- sv/ism_front.sv -----
// front end: accepts instructions, drops unused codes, queues requests
`default_nettype none
module ism_front import ism_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic signed [VAL_W-1:0] in_operand,
  output logic             q_valid,
  input  wire logic        q_ready,
  output ism_req_t         q_req
);

  ism_req_t          buf_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop, known;
  ism_req_t          req;

  // classify the incoming command
  always_comb begin
    known         = (in_cmd <= CMD_END);
    req.cmd       = in_cmd;
    req.operand   = in_operand;
    unique case (in_cmd) inside
      CMD_SWP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: req.needs_two = 1'b1;
      default: req.needs_two = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_req    = buf_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= req;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ism_div.sv -----
// iterative signed divider, one quotient bit per cycle
`default_nettype none
module ism_div import ism_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [VAL_W-1:0] dividend,
  input  wire logic signed [VAL_W-1:0] divisor,
  output logic                         done,
  output logic signed [VAL_W:0]        quot,
  output logic signed [VAL_W:0]        rem
);

  localparam int STEP_W = $clog2(VAL_W + 1);

  logic [VAL_W:0]    rem_r, rem_nxt;
  logic [VAL_W-1:0]  quo_r, quo_nxt;
  logic [VAL_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic              done_r, done_nxt;
  logic [VAL_W:0]    shifted, diff;

  // operand load on start, else one restoring step while busy
  always_comb begin
    shifted  = {rem_r[VAL_W-1:0], quo_r[VAL_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
      dvs_nxt  = divisor[VAL_W-1] ? VAL_W'(-divisor) : VAL_W'(divisor);
      qneg_nxt = dividend[VAL_W-1] ^ divisor[VAL_W-1];
      rneg_nxt = dividend[VAL_W-1];
      step_nxt = STEP_W'(VAL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VAL_W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // apply signs to the magnitudes
  assign done = done_r;
  assign quot = qneg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign rem  = rneg_r ? -$signed({1'b0, rem_r[VAL_W-1:0]})
                       : $signed({1'b0, rem_r[VAL_W-1:0]});

endmodule
`default_nettype wire

// ----- sv/ism_exec.sv -----
// back end: executes requests on a cached top of stack over a stack memory
`default_nettype none
module ism_exec import ism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire ism_req_t q_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic          out_err
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RFL  = 3'd3;
  localparam logic [2:0] ST_CAP  = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      err_r, err_nxt;
  logic signed [VAL_W-1:0]   tos_r, tos_nxt, nos_r, nos_nxt;
  logic [CMD_W-1:0]          op_r, op_nxt;
  logic signed [2*VAL_W-1:0] prod_r, prod_nxt;
  logic                      ovalid_r, ovalid_nxt, oerr_r, oerr_nxt;
  logic signed [VAL_W-1:0]   oval_r, oval_nxt;

  // stack memory holds the entries below the two cached ones
  logic signed [VAL_W-1:0]   mem [STACK_DEPTH];
  logic signed [VAL_W-1:0]   rd_data_r;
  logic                      wr_en, rd_en;
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  logic [CNT_W-1:0]          cnt_m2;

  logic                      div_start, div_done;
  logic signed [VAL_W:0]     div_q, div_r, div_sel;
  logic signed [VAL_W:0]     sum;
  logic signed [VAL_W-1:0]   push_val;

  ism_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (nos_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign cnt_m2  = count_r - CNT_W'(2);
  assign wr_addr = cnt_m2[ADDR_W-1:0];
  assign rd_addr = cnt_m2[ADDR_W-1:0];
  assign div_sel = (op_r == CMD_DIV) ? div_q : div_r;

  // main sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    tos_nxt    = tos_r;
    nos_nxt    = nos_r;
    op_nxt     = op_r;
    prod_nxt   = prod_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oval_nxt   = oval_r;
    oerr_nxt   = oerr_r;
    q_ready    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    sum        = '0;
    push_val   = (q_req.cmd == CMD_DUP) ? tos_r : q_req.operand;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && !(q_req.cmd == CMD_END && ovalid_r)) begin
          q_ready = 1'b1;
          if (q_req.cmd == CMD_START) begin
            count_nxt = CNT_W'(1);
            err_nxt   = 1'b0;
            tos_nxt   = q_req.operand;
          end else if (q_req.cmd == CMD_END) begin
            ovalid_nxt = 1'b1;
            if (err_r || count_r != CNT_W'(1)) begin
              oval_nxt = '0;
              oerr_nxt = 1'b1;
            end else begin
              oval_nxt = tos_r;
              oerr_nxt = 1'b0;
            end
          end else if (err_r) begin
            // sticky error: command is skipped
          end else if (q_req.needs_two && count_r < CNT_W'(2)) begin
            err_nxt = 1'b1;
          end else begin
            case (q_req.cmd)
              CMD_NUM, CMD_DUP: begin
                if (q_req.cmd == CMD_DUP && count_r == '0) begin
                  err_nxt = 1'b1;
                end else if (count_r >= CNT_W'(STACK_DEPTH)) begin
                  err_nxt = 1'b1;
                end else begin
                  wr_en     = (count_r >= CNT_W'(2));
                  nos_nxt   = tos_r;
                  tos_nxt   = push_val;
                  count_nxt = count_r + 1'b1;
                end
              end
              CMD_POP: begin
                if (count_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  tos_nxt   = nos_r;
                  count_nxt = count_r - 1'b1;
                  state_nxt = ST_RFL;
                end
              end
              CMD_INV: begin
                sum = -(VAL_W+1)'(tos_r);
                if (count_r == '0 || too_big(64'(sum))) begin
                  err_nxt = 1'b1;
                end else begin
                  tos_nxt = sum[VAL_W-1:0];
                end
              end
              CMD_SWP: begin
                tos_nxt = nos_r;
                nos_nxt = tos_r;
              end
              CMD_ADD, CMD_SUB: begin
                sum = (q_req.cmd == CMD_ADD) ? (VAL_W+1)'(nos_r) + (VAL_W+1)'(tos_r)
                                             : (VAL_W+1)'(nos_r) - (VAL_W+1)'(tos_r);
                if (too_big(64'(sum))) begin
                  err_nxt = 1'b1;
                end else begin
                  tos_nxt   = sum[VAL_W-1:0];
                  count_nxt = count_r - 1'b1;
                  state_nxt = ST_RFL;
                end
              end
              CMD_MUL: begin
                prod_nxt  = (2*VAL_W)'(nos_r) * (2*VAL_W)'(tos_r);
                state_nxt = ST_MUL;
              end
              CMD_DIV, CMD_MOD: begin
                if (tos_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  div_start = 1'b1;
                  op_nxt    = q_req.cmd;
                  state_nxt = ST_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_IDLE;
        if (too_big(64'(prod_r))) begin
          err_nxt = 1'b1;
        end else begin
          tos_nxt   = prod_r[VAL_W-1:0];
          count_nxt = count_r - 1'b1;
          state_nxt = ST_RFL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
          if (too_big(64'(div_sel))) begin
            err_nxt = 1'b1;
          end else begin
            tos_nxt   = div_sel[VAL_W-1:0];
            count_nxt = count_r - 1'b1;
            state_nxt = ST_RFL;
          end
        end
      end
      ST_RFL: begin
        // fetch the new second entry from memory
        if (count_r >= CNT_W'(2)) begin
          rd_en     = 1'b1;
          state_nxt = ST_CAP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CAP: begin
        nos_nxt   = rd_data_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r  <= tos_nxt;
    nos_r  <= nos_nxt;
    op_r   <= op_nxt;
    prod_r <= prod_nxt;
    oval_r <= oval_nxt;
    oerr_r <= oerr_nxt;
  end

  // stack memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= nos_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = ovalid_r;
  assign out_value = oval_r;
  assign out_err   = oerr_r;

endmodule
`default_nettype wire

// ----- sv/ism_checker.sv -----
// port-level checks of the integer stack machine, bound to the top level
`default_nettype none
module ism_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |-> out_tdata[30:0] == 31'd0)
    else $error("error result with nonzero value");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a result never appears straight out of reset
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rst_n))
    else $error("result appeared straight out of reset");

  // a stalled request stays offered with the same data
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while stalled");

endmodule

bind integer_stack_machine_top ism_checker u_ism_checker (.*);
`default_nettype wire
